@@ rtl/thlm_pkg.sv @@
// thlm_pkg: shared types and constants for the tree lock manager
// no dependencies
`timescale 1ns / 1ps
package thlm_pkg;
  localparam int FuncW = 2;
  localparam int NodeW = 6;
  localparam int UserW = 16;
  localparam int BfW   = 4;
  localparam int NcW   = 7;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOCK    = 2'd0,
    FUNC_UNLOCK  = 2'd1,
    FUNC_UPGRADE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  localparam logic [CfgIdxW-1:0] REG_BRANCH = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_NODES  = 1'b1;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [NodeW-1:0] node_index;
    logic [UserW-1:0] user_id;
  } req_t;

  typedef struct packed {
    logic success;
  } rsp_t;
endpackage

@@ rtl/thlm_if.sv @@
// thlm_if: valid/ready channel carrying a request or response word
// depends on thlm_pkg
`timescale 1ns / 1ps
interface thlm_req_if;
  logic valid;
  logic ready;
  thlm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface thlm_rsp_if;
  logic valid;
  logic ready;
  thlm_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/thlm_anc.sv @@
// thlm_anc: shared ancestor test unit, one parent step per cycle
// thlm_par: parent index of a level-order node by reciprocal multiply
// depends on thlm_pkg
`timescale 1ns / 1ps
module thlm_par #(
  parameter int IdxW = 6
) (
  input  logic [IdxW-1:0] idx,
  input  logic [thlm_pkg::BfW-1:0] arity,
  output logic [IdxW-1:0] par
);
  // four guard bits keep the floor exact for every arity up to 15
  localparam int RS = IdxW + 4;
  localparam int RW = RS + 1;
  localparam int PW = IdxW + RW;
  localparam logic [RW-1:0] R1  = RW'(2 ** RS);
  localparam logic [RW-1:0] R2  = RW'((2 ** RS + 1) / 2);
  localparam logic [RW-1:0] R3  = RW'((2 ** RS + 2) / 3);
  localparam logic [RW-1:0] R4  = RW'((2 ** RS + 3) / 4);
  localparam logic [RW-1:0] R5  = RW'((2 ** RS + 4) / 5);
  localparam logic [RW-1:0] R6  = RW'((2 ** RS + 5) / 6);
  localparam logic [RW-1:0] R7  = RW'((2 ** RS + 6) / 7);
  localparam logic [RW-1:0] R8  = RW'((2 ** RS + 7) / 8);
  localparam logic [RW-1:0] R9  = RW'((2 ** RS + 8) / 9);
  localparam logic [RW-1:0] R10 = RW'((2 ** RS + 9) / 10);
  localparam logic [RW-1:0] R11 = RW'((2 ** RS + 10) / 11);
  localparam logic [RW-1:0] R12 = RW'((2 ** RS + 11) / 12);
  localparam logic [RW-1:0] R13 = RW'((2 ** RS + 12) / 13);
  localparam logic [RW-1:0] R14 = RW'((2 ** RS + 13) / 14);
  localparam logic [RW-1:0] R15 = RW'((2 ** RS + 14) / 15);

  logic [IdxW-1:0] dec;
  logic [RW-1:0] rcp;
  logic [PW-1:0] prod;

  assign dec = idx - IdxW'(1);

  always_comb begin
    unique case (arity)
      thlm_pkg::BfW'(2):  rcp = R2;
      thlm_pkg::BfW'(3):  rcp = R3;
      thlm_pkg::BfW'(4):  rcp = R4;
      thlm_pkg::BfW'(5):  rcp = R5;
      thlm_pkg::BfW'(6):  rcp = R6;
      thlm_pkg::BfW'(7):  rcp = R7;
      thlm_pkg::BfW'(8):  rcp = R8;
      thlm_pkg::BfW'(9):  rcp = R9;
      thlm_pkg::BfW'(10): rcp = R10;
      thlm_pkg::BfW'(11): rcp = R11;
      thlm_pkg::BfW'(12): rcp = R12;
      thlm_pkg::BfW'(13): rcp = R13;
      thlm_pkg::BfW'(14): rcp = R14;
      thlm_pkg::BfW'(15): rcp = R15;
      default: rcp = R1;
    endcase
  end

  assign prod = PW'(dec) * PW'(rcp);
  assign par  = prod[RS +: IdxW];
endmodule

module thlm_anc #(
  parameter int IdxW = 6
) (
  input  logic clk,
  input  logic start,
  input  logic [IdxW-1:0] anc,
  input  logic [IdxW-1:0] node,
  input  logic [thlm_pkg::BfW-1:0] arity,
  output logic done,
  output logic hit
);
  logic [IdxW-1:0] cur;
  logic busy;
  logic [IdxW-1:0] par;

  thlm_par #(.IdxW(IdxW)) u_par (
    .idx(cur), .arity(arity), .par(par)
  );

  assign done = busy && (cur <= anc);
  assign hit  = done && (cur == anc);

  always_ff @(posedge clk) begin
    if (start) begin
      cur  <= node;
      busy <= 1'b1;
    end else if (busy && cur > anc) begin
      cur <= par;
    end else begin
      busy <= 1'b0;
    end
  end
endmodule

@@ rtl/tree_hierarchical_lock_manager.sv @@
// tree_hierarchical_lock_manager: sequencer over per-node lock memories
// depends on thlm_pkg, thlm_if, thlm_anc
// a request refused in S_CHECK goes straight to S_RESP; a granted lock or unlock
// request walks ancestors one per cycle, then scans nodes with the shared ancestor
// test unit, one parent step per cycle; an upgrade first checks the owners of locked
// descendants, then unlocks each owned descendant and locks the target
// throughput: one request at a time; ready low while busy
// reset: config to defaults, then a clearing pass over all MAX_NODES entries (also
// after any config write)
`timescale 1ns / 1ps
module tree_hierarchical_lock_manager #(
  parameter int MAX_NODES = 64
) (
  input  logic clk,
  input  logic rst,
  thlm_req_if.sink   req,
  thlm_rsp_if.source rsp,
  input  logic cfg_we,
  input  logic [thlm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [thlm_pkg::CfgDataW-1:0] cfg_data
);
  localparam int IdxW = $clog2(MAX_NODES);
  localparam int CntW = IdxW + 1;
  localparam int PrW  = (CntW > thlm_pkg::NcW) ? CntW : thlm_pkg::NcW;
  localparam int CmpW = (CntW > thlm_pkg::NodeW) ? CntW : thlm_pkg::NodeW;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_SCANR = 9'b000001000,
    S_SCANT = 9'b000010000,
    S_ANC   = 9'b000100000,
    S_DESC  = 9'b001000000,
    S_UPANC = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  state_t state;
  logic [thlm_pkg::BfW-1:0] bf;
  logic [thlm_pkg::NcW-1:0] nc;
  logic [thlm_pkg::BfW-1:0] arity;
  logic [CntW-1:0] present;

  logic         lk   [MAX_NODES];
  logic [15:0]  own  [MAX_NODES];
  logic [CntW-1:0] ac [MAX_NODES];
  logic [CntW-1:0] dc [MAX_NODES];

  logic [thlm_pkg::FuncW-1:0] func;
  logic [IdxW-1:0] t, tgt, k, j;
  logic [15:0] user;
  logic on, ok, upg, pass2;
  logic [CntW-1:0] clr;
  logic anc_start, anc_done, anc_hit;
  logic [IdxW-1:0] jpar;
  logic kwait;
  logic [CntW-1:0] knext;
  logic inr, apend;
  logic [IdxW-1:0] ra;
  logic rd_lk;
  logic [15:0] rd_own;
  logic [CntW-1:0] rd_ac, rd_dc;

  assign arity = (bf == '0) ? thlm_pkg::BfW'(1) : bf;
  assign present = (PrW'(nc) > PrW'(MAX_NODES)) ? CntW'(MAX_NODES) : CntW'(nc);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_RESP);
  assign rsp.data.success = ok;

  assign knext = CntW'(k) + CntW'(1);
  assign anc_start = (state == S_SCANR || state == S_SCANT || state == S_DESC) && !kwait;

  thlm_anc #(.IdxW(IdxW)) u_anc (
    .clk(clk), .start(anc_start), .anc(tgt), .node(knext[IdxW-1:0]), .arity(arity),
    .done(anc_done), .hit(anc_hit)
  );

  thlm_par #(.IdxW(IdxW)) u_jpar (
    .idx(j), .arity(arity), .par(jpar)
  );

  // one read address per cycle, read data is registered and lands in the next cycle
  assign ra = (state == S_IDLE) ? IdxW'(req.data.node_index) :
              (state == S_ANC)  ? jpar : k;

  always_ff @(posedge clk) begin
    rd_lk  <= lk[ra];
    rd_own <= own[ra];
    rd_ac  <= ac[ra];
    rd_dc  <= dc[ra];
    if (rst) begin
      state <= S_CLEAR;
      bf <= thlm_pkg::BfW'(2);
      nc <= thlm_pkg::NcW'(64);
      clr <= '0;
      kwait <= 1'b0;
      apend <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == thlm_pkg::REG_BRANCH) bf <= cfg_data[thlm_pkg::BfW-1:0];
        else nc <= cfg_data;
        state <= S_CLEAR;
        clr <= '0;
        kwait <= 1'b0;
        apend <= 1'b0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            lk[clr[IdxW-1:0]] <= 1'b0;
            own[clr[IdxW-1:0]] <= '0;
            ac[clr[IdxW-1:0]] <= '0;
            dc[clr[IdxW-1:0]] <= '0;
            clr <= clr + CntW'(1);
            if (clr == CntW'(MAX_NODES - 1)) state <= S_IDLE;
          end
          S_IDLE: if (req.valid) begin
            func <= req.data.func;
            t <= IdxW'(req.data.node_index);
            user <= req.data.user_id;
            inr <= (CmpW'(req.data.node_index) < CmpW'(present));
            state <= S_CHECK;
          end
          S_CHECK: begin
            ok <= 1'b0;
            state <= S_RESP;
            tgt <= t;
            k <= t;
            kwait <= 1'b0;
            apend <= 1'b0;
            j <= t;
            if (inr) begin
              if (func == thlm_pkg::FUNC_LOCK) begin
                if (!rd_lk && rd_ac == '0 && rd_dc == '0) begin
                  on <= 1'b1; upg <= 1'b0; ok <= 1'b1; state <= S_ANC;
                end
              end else if (func == thlm_pkg::FUNC_UNLOCK) begin
                if (rd_lk && rd_own == user) begin
                  on <= 1'b0; upg <= 1'b0; ok <= 1'b1; state <= S_ANC;
                end
              end else if (func == thlm_pkg::FUNC_UPGRADE) begin
                if (!rd_lk && rd_ac == '0 && rd_dc != '0) begin
                  ok <= 1'b1; pass2 <= 1'b0; state <= S_SCANT;
                end
              end
            end
          end
          // upgrade: verify owners, then unlock owned descendants and lock the target
          S_SCANT: begin
            if (!kwait) begin
              if (knext >= present) begin
                if (!pass2) begin
                  pass2 <= 1'b1; k <= t;
                end else begin
                  tgt <= t; j <= t; on <= 1'b1; upg <= 1'b0; k <= t; state <= S_ANC;
                end
              end else begin
                k <= knext[IdxW-1:0]; kwait <= 1'b1;
              end
            end else if (anc_done) begin
              kwait <= 1'b0;
              if (anc_hit && rd_lk) begin
                if (!pass2) begin
                  if (rd_own != user) begin ok <= 1'b0; state <= S_RESP; end
                end else begin
                  tgt <= k; j <= k; on <= 1'b0; upg <= 1'b1; state <= S_ANC;
                end
              end
            end
          end
          S_SCANR: state <= S_SCANR;
          // walk ancestors, adjust descendant counts one step behind the read, then set the target's lock
          S_ANC: begin
            if (apend) dc[j] <= on ? rd_dc + CntW'(1) : rd_dc - CntW'(1);
            if (j == '0) begin
              lk[tgt] <= on;
              if (on) own[tgt] <= user;
              state <= S_DESC; k <= tgt; kwait <= 1'b0; apend <= 1'b0;
            end else begin
              j <= jpar;
              apend <= 1'b1;
            end
          end
          // scan descendants, adjust ancestor counts
          S_DESC: begin
            if (!kwait) begin
              if (knext >= present) begin
                if (upg) begin state <= S_SCANT; k <= tgt; tgt <= t; end
                else state <= S_RESP;
              end else begin
                k <= knext[IdxW-1:0]; kwait <= 1'b1;
              end
            end else if (anc_done) begin
              kwait <= 1'b0;
              if (anc_hit) ac[k] <= on ? rd_ac + CntW'(1) : rd_ac - CntW'(1);
            end
          end
          S_UPANC: state <= S_RESP;
          S_RESP: if (rsp.ready) state <= S_IDLE;
          default: state <= S_CLEAR;
        endcase
      end
    end
  end
endmodule
